[rtl/core/wgkde_pkg.sv]
// shared types, constants and the exp(-t) table for the weighted gaussian kde unit
// no dependencies
package wgkde_pkg;

  localparam int DEF_MAX_POINTS     = 256;
  localparam int DEF_MAX_COMPONENTS = 8;
  localparam int DEF_MAX_COORDS     = 8;
  localparam int EXP_TABLE_SIZE     = 256;
  localparam int EXP_CUTOFF         = 16;
  localparam int RESULT_LIMIT       = 8;
  localparam int IDX_W              = $clog2(EXP_TABLE_SIZE);
  localparam int KCNT_W             = 4;

  localparam logic [1:0] OP_LOAD_SAMPLE = 2'd0;
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  localparam logic [2:0] REG_POINT_COUNT     = 3'd0;
  localparam logic [2:0] REG_COMPONENT_COUNT = 3'd1;
  localparam logic [2:0] REG_COORD_COUNT     = 3'd2;
  localparam logic [2:0] REG_EXP_SCALE       = 3'd3;
  localparam logic [2:0] REG_DENSITY_SCALE   = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         point_index;
    logic [2:0]         column_index;
    logic signed [31:0] sample_value;
    logic [16:0]        weight_value;
  } kde_in_t;

  typedef struct packed {
    logic [2:0]  coord_out;
    logic [31:0] density;
    logic [31:0] density_product;
    logic        saturated;
    logic        last;
  } kde_out_t;

  typedef logic [EXP_TABLE_SIZE-1:0][15:0] exp_tab_t;

  // q0.30 taylor series for the step factor, then repeated q0.32 products
  function automatic exp_tab_t build_exp_table();
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] base;
    logic [63:0] v;
    logic [63:0] e;
    exp_tab_t    tab;
    x    = (64'(EXP_CUTOFF) << 30) / 64'(EXP_TABLE_SIZE);
    term = 64'd1 << 30;
    s    = 64'd1 << 30;
    v    = 64'd1 << 32;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * x) >> 30) / 64'(n);
      if ((n & 1) != 0) s = s - term;
      else s = s + term;
    end
    base = s << 2;
    for (int n = 0; n < EXP_TABLE_SIZE; n++) begin
      e = (v + (64'd1 << 15)) >> 16;
      if (e > 64'd65535) e = 64'd65535;
      tab[n] = e[15:0];
      v = (v * base + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

endpackage

[rtl/core/weighted_gaussian_kde_unit.sv]
// weighted gaussian kernel density estimate: top level, query sequencer and stores
// depends on wgkde_pkg, wgkde_ram, wgkde_kernel
//
// input channel (in_valid / in_stall / in_data) takes load and query beats.
// a sample or weight load is written to its store in the cycle it is taken,
// and the unit is ready again on the next cycle. a query for point i and
// component j produces min(coord_count, MAX_COORDS, RESULT_LIMIT) output
// beats (out_valid / out_stall / out_data), one per coordinate, last set on
// the final one. each coordinate reads its own sample (S_XI_RD, S_XI_CAP),
// streams point_count points (at most MAX_POINTS) through the kernel pipeline
// at one point per cycle from the two store read ports, waits in S_DRAIN for
// the read and six kernel stages to drain and then goes through S_DENS,
// S_DSAT and S_OUT for scaling, the product and loading the output register.
// in_stall stays high for the whole query. the output register holds a beat
// while out_stall is high; the next coordinate is computed meanwhile and waits
// for the register to free up.
// reset clears control state and config registers to their defaults; store
// contents are undefined until loaded and no clearing pass runs.
// config writes (cfg_we / cfg_index / cfg_data) belong in idle periods only.
module weighted_gaussian_kde_unit
  import wgkde_pkg::*;
#(
  parameter int MAX_POINTS     = DEF_MAX_POINTS,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS,
  parameter int MAX_COORDS     = DEF_MAX_COORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  kde_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output kde_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SDEPTH = MAX_POINTS * MAX_COORDS;
  localparam int WDEPTH = MAX_POINTS * MAX_COMPONENTS;
  localparam int SA_W   = $clog2(SDEPTH);
  localparam int WA_W   = $clog2(WDEPTH);
  localparam int PT_W   = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = 33 + $clog2(MAX_POINTS);
  localparam int DSH_W  = SUM_W - 8;

  typedef enum logic [2:0] {
    S_IDLE, S_XI_RD, S_XI_CAP, S_RUN, S_DRAIN, S_DENS, S_DSAT, S_OUT
  } state_t;

  state_t state;

  logic [8:0]  point_count;
  logic [3:0]  component_count;
  logic [3:0]  coord_count;
  logic [31:0] exp_scale;
  logic [23:0] density_scale;

  logic [7:0]        q_i;
  logic [2:0]        q_col;
  logic [PT_W-1:0]   n_eff;
  logic [KCNT_W-1:0] r_eff;
  logic [KCNT_W-1:0] k;
  logic [PT_W-1:0]   ii;
  logic [PT_W-1:0]   term_cnt;
  logic [SUM_W-1:0]  sum;
  logic [31:0]       xi;
  logic [DSH_W+23:0] dens_wide;
  logic [31:0]       dens;
  logic [63:0]       prod_wide;
  logic [31:0]       prod;
  logic              sat;
  logic              rd_valid;

  logic        fire;
  logic        can_load;
  logic [12:0] n_calc;
  logic [4:0]  r_calc;
  logic        q_ok;
  logic        s_we, w_we;
  logic        s_re;
  logic [SA_W-1:0] s_waddr, s_raddr;
  logic [WA_W-1:0] w_waddr, w_raddr;
  logic [31:0] s_rdata;
  logic [16:0] w_rdata;
  logic        term_valid;
  logic [32:0] term;
  logic [DSH_W-1:0] dens_sh;
  logic [47:0] prod_sh;
  logic        dens_over, prod_over;

  assign in_stall = (state != S_IDLE);
  assign fire     = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;

  always_comb begin
    n_calc = (13'(point_count) > 13'(MAX_POINTS)) ? 13'(MAX_POINTS) : 13'(point_count);
    r_calc = 5'(coord_count);
    if (r_calc > 5'(MAX_COORDS)) r_calc = 5'(MAX_COORDS);
    if (r_calc > 5'(RESULT_LIMIT)) r_calc = 5'(RESULT_LIMIT);
    q_ok = (13'(in_data.point_index) < n_calc) &&
           (4'(in_data.column_index) < component_count) &&
           (32'(in_data.column_index) < 32'(MAX_COMPONENTS)) && (r_calc != 5'd0);
  end

  // loads go straight into the stores
  assign s_we = fire && (in_data.operation == OP_LOAD_SAMPLE) &&
                (32'(in_data.point_index) < 32'(MAX_POINTS)) &&
                (32'(in_data.column_index) < 32'(MAX_COORDS));
  assign w_we = fire && (in_data.operation == OP_LOAD_WEIGHT) &&
                (32'(in_data.point_index) < 32'(MAX_POINTS)) &&
                (32'(in_data.column_index) < 32'(MAX_COMPONENTS));
  assign s_waddr = SA_W'(SA_W'(in_data.point_index) * SA_W'(MAX_COORDS) +
                         SA_W'(in_data.column_index));
  assign w_waddr = WA_W'(WA_W'(in_data.point_index) * WA_W'(MAX_COMPONENTS) +
                         WA_W'(in_data.column_index));

  assign s_re    = (state == S_XI_RD) || (state == S_RUN);
  assign s_raddr = (state == S_XI_RD) ?
                   SA_W'(SA_W'(q_i) * SA_W'(MAX_COORDS) + SA_W'(k)) :
                   SA_W'(SA_W'(ii) * SA_W'(MAX_COORDS) + SA_W'(k));
  assign w_raddr = WA_W'(WA_W'(ii) * WA_W'(MAX_COMPONENTS) + WA_W'(q_col));

  wgkde_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_sample_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_data.sample_value),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  wgkde_ram #(.WIDTH(17), .DEPTH(WDEPTH)) u_weight_ram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(in_data.weight_value),
    .re(state == S_RUN), .raddr(w_raddr), .rdata(w_rdata)
  );

  wgkde_kernel u_kernel (
    .clk(clk), .rst(rst), .in_valid(rd_valid), .xi(xi), .xs(s_rdata), .w(w_rdata),
    .exp_scale(exp_scale), .term_valid(term_valid), .term(term)
  );

  assign dens_sh   = dens_wide[DSH_W+23:24];
  assign dens_over = 64'(dens_sh) > 64'hFFFF_FFFF;
  assign prod_sh   = prod_wide[63:16];
  assign prod_over = prod_sh > 48'h0000_FFFF_FFFF;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      point_count     <= 9'd1;
      component_count <= 4'd1;
      coord_count     <= 4'd1;
      exp_scale       <= 32'd16777216;
      density_scale   <= 24'd65536;
      out_valid       <= 1'b0;
      rd_valid        <= 1'b0;
      ii              <= '0;
      term_cnt        <= '0;
      k               <= '0;
    end else begin
      rd_valid <= (state == S_RUN);
      if (out_valid && !out_stall && (state != S_OUT)) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_POINT_COUNT:     point_count     <= cfg_data[8:0];
          REG_COMPONENT_COUNT: component_count <= cfg_data[3:0];
          REG_COORD_COUNT:     coord_count     <= cfg_data[3:0];
          REG_EXP_SCALE:       exp_scale       <= cfg_data;
          REG_DENSITY_SCALE:   density_scale   <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (term_valid) begin
        sum      <= sum + SUM_W'(term);
        term_cnt <= term_cnt + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (fire && (in_data.operation == OP_QUERY) && q_ok) begin
            q_i   <= in_data.point_index;
            q_col <= in_data.column_index;
            n_eff <= PT_W'(n_calc);
            r_eff <= KCNT_W'(r_calc);
            k     <= '0;
            sat   <= 1'b0;
            state <= S_XI_RD;
          end
        end
        S_XI_RD: begin
          ii       <= '0;
          term_cnt <= '0;
          sum      <= '0;
          state    <= S_XI_CAP;
        end
        S_XI_CAP: begin
          xi    <= s_rdata;
          state <= S_RUN;
        end
        S_RUN: begin
          ii <= ii + 1'b1;
          if (ii == n_eff - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (term_cnt == n_eff) state <= S_DENS;
        end
        S_DENS: begin
          dens_wide <= (DSH_W+24)'(sum[SUM_W-1:8]) * (DSH_W+24)'(density_scale);
          state     <= S_DSAT;
        end
        S_DSAT: begin
          dens <= dens_over ? 32'hFFFF_FFFF : dens_sh[31:0];
          if (dens_over) sat <= 1'b1;
          // first coordinate: product starts at the density itself
          if (k == '0) prod_wide <= {16'd0, (dens_over ? 32'hFFFF_FFFF : dens_sh[31:0]), 16'd0};
          else prod_wide <= 64'(prod) * 64'(dens_over ? 32'hFFFF_FFFF : dens_sh[31:0]);
          state <= S_OUT;
        end
        S_OUT: begin
          if (can_load) begin
            out_valid                <= 1'b1;
            out_data.coord_out       <= k[2:0];
            out_data.density         <= dens;
            out_data.density_product <= prod_over ? 32'hFFFF_FFFF : prod_sh[31:0];
            out_data.saturated       <= sat || prod_over;
            out_data.last            <= (k + 1'b1 == r_eff);
            prod                     <= prod_over ? 32'hFFFF_FFFF : prod_sh[31:0];
            if (prod_over) sat <= 1'b1;
            if (k + 1'b1 == r_eff) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_XI_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_terms_follow_issues: assert property (@(posedge clk) disable iff (rst)
    term_cnt <= ii) else $error("more kernel terms than issued reads");

  a_drained_before_scale: assert property (@(posedge clk) disable iff (rst)
    state == S_DENS |-> term_cnt == n_eff) else $error("scaling before pipeline drained");

  a_run_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> ii < n_eff) else $error("point read beyond point count");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("stalled output beat dropped");

endmodule

[rtl/core/wgkde_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module wgkde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

[rtl/core/wgkde_kernel.sv]
// six stage pipeline: weight times exp(-(xi-xs)^2 * exp_scale) from the exp table
// depends on wgkde_pkg
module wgkde_kernel
  import wgkde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] xi,
  input  logic [31:0] xs,
  input  logic [16:0] w,
  input  logic [31:0] exp_scale,
  output logic        term_valid,
  output logic [32:0] term
);

  localparam int       LIM   = EXP_CUTOFF << 16;
  localparam int       LIM_W = $clog2(LIM);
  localparam exp_tab_t TAB   = build_exp_table();

  logic [5:0]       v;
  logic [31:0]      u1;
  logic [63:0]      d2;
  logic [63:0]      p0;
  logic [63:0]      p1;
  logic [IDX_W-1:0] idx4;
  logic             cut4;
  logic [15:0]      kern5;
  logic [16:0]      w1, w2, w3, w4, w5;

  logic signed [32:0] diff;
  logic [63:0]        t;

  assign diff = $signed({xi[31], xi}) - $signed({xs[31], xs});
  // q.16 argument, same as the full product shifted right by 40
  assign t    = (p1 >> 8) + ((64'(p1[7:0]) + (p0 >> 32)) >> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:0], in_valid};
    end
    u1    <= diff[32] ? 32'(-diff) : diff[31:0];
    w1    <= w;
    d2    <= 64'(u1) * 64'(u1);
    w2    <= w1;
    p0    <= 64'(d2[31:0]) * 64'(exp_scale);
    p1    <= 64'(d2[63:32]) * 64'(exp_scale);
    w3    <= w2;
    cut4  <= t >= 64'(LIM);
    idx4  <= IDX_W'((64'(t[LIM_W-1:0]) * 64'(EXP_TABLE_SIZE)) / 64'(LIM));
    w4    <= w3;
    kern5 <= cut4 ? 16'd0 : TAB[idx4];
    w5    <= w4;
    term  <= 33'(w5) * 33'(kern5);
  end

  assign term_valid = v[5];

endmodule
